@@ sv/assert_macros.svh @@
// Assertion macros shared by the box blur RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BB3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BB3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bb3_pkg.sv @@
// Shared constants, types and helper functions of the 3x3 box blur.
`timescale 1ns / 1ps

package bb3_pkg;

  // Line store geometry
  localparam int MAX_W  = 1024;
  localparam int COL_W  = $clog2(MAX_W);
  localparam int EW_W   = $clog2(MAX_W + 1);

  // Field and register widths
  localparam int CH_W       = 8;
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 16;
  localparam int ROW_W      = 16;
  localparam int IROW_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HCFG_W-1:0] HEIGHT_RST = 16'd480;

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Arithmetic widths: sum of nine 8-bit values, rounding numerator 2*sum+count,
  // reciprocal of 2*count scaled by 2^RCP_SH
  localparam int SUM_W  = 12;
  localparam int CNT_W  = 4;
  localparam int X_W    = 13;
  localparam int RCP_W  = 18;
  localparam int RCP_SH = 18;
  localparam int PROD_W = X_W + RCP_W;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // One advance of the window, as handed from front to back
  typedef struct packed {
    pix_t above;
    pix_t middle;
    pix_t pix;
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } bb3_op_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_READ,
    FE_WRITE
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SUM,
    BK_DIV
  } bk_state_t;

  // ceil(2^RCP_SH / (2*cnt)); exact floor division for every numerator below 2^X_W
  function automatic logic [RCP_W-1:0] bb3_recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    case (cnt)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd6:    r = 18'd21846;
      4'd9:    r = 18'd14564;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bb3_front.sv @@
// Front end: takes requests, runs the line stores and position counters.
`timescale 1ns / 1ps

module bb3_front import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  input  logic [WCFG_W-1:0] cfg_width,
  input  logic [HCFG_W-1:0] cfg_height,
  input  logic              q_full,
  output logic              q_push,
  output bb3_op_t           q_data
);

  localparam int CMP_W = (EW_W > WCFG_W) ? EW_W : WCFG_W;
  localparam logic [1:0] DRN_LAST = 2'd2;

  fe_state_t st_r, st_nxt;

  logic [COL_W-1:0]  ic_r, ic_nxt, oc_r, oc_nxt;
  logic [IROW_W-1:0] ir_r, ir_nxt;
  logic [ROW_W-1:0]  or_r, or_nxt;
  logic [1:0]        dcnt_r, dcnt_nxt;
  logic              drain_r, drain_nxt;
  pix_t              pix_r, pix_nxt;

  pix_t upper_mem  [MAX_W];
  pix_t middle_mem [MAX_W];
  pix_t up_q, mid_q;

  logic [CMP_W-1:0]  wcmp;
  logic [EW_W-1:0]   ew;
  logic [HCFG_W-1:0] eh;
  logic accept, take, complete, ic_last, oc_last, or_last, emit, last, more, rd_en;

  // Effective image size
  always_comb begin
    wcmp = CMP_W'(cfg_width);
    if (wcmp == '0) begin
      wcmp = CMP_W'(1);
    end else if (wcmp > CMP_W'(MAX_W)) begin
      wcmp = CMP_W'(MAX_W);
    end
    ew = EW_W'(wcmp);
    eh = (cfg_height == '0) ? HCFG_W'(1) : cfg_height;
  end

  assign accept   = in_valid && !in_stall;
  assign complete = ir_r >= IROW_W'(eh);
  assign take     = accept && (((in_req_type == REQ_PIXEL) && !complete) ||
                               ((in_req_type == REQ_DRAIN) && complete));

  assign ic_last = (EW_W'(ic_r) + EW_W'(1)) >= ew;
  assign oc_last = (EW_W'(oc_r) + EW_W'(1)) >= ew;
  assign or_last = (IROW_W'(or_r) + IROW_W'(1)) >= IROW_W'(eh);
  assign emit    = (ic_r == '0) ? (ir_r >= IROW_W'(2)) : (ir_r != '0);
  assign last    = emit && or_last && oc_last;
  assign more    = drain_r && !emit && (dcnt_r != DRN_LAST);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FE_IDLE:  if (take) st_nxt = FE_WRITE;
      FE_READ:  st_nxt = FE_WRITE;
      FE_WRITE: if (!q_full) st_nxt = more ? FE_READ : FE_IDLE;
      default:  st_nxt = FE_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    rd_en    = 1'b1;
    case (st_r)
      FE_IDLE:  in_stall = 1'b0;
      FE_READ:  rd_en = 1'b1;
      FE_WRITE: begin
        rd_en  = 1'b0;
        q_push = !q_full;
      end
      default:  in_stall = 1'b1;
    endcase
  end

  // Counters and request latch
  always_comb begin
    ic_nxt    = ic_r;
    ir_nxt    = ir_r;
    oc_nxt    = oc_r;
    or_nxt    = or_r;
    dcnt_nxt  = dcnt_r;
    drain_nxt = drain_r;
    pix_nxt   = pix_r;
    if (take) begin
      drain_nxt = (in_req_type == REQ_DRAIN);
      dcnt_nxt  = '0;
      pix_nxt   = (in_req_type == REQ_PIXEL) ? pix_t'({in_red, in_green, in_blue}) : '0;
    end
    if (q_push) begin
      ic_nxt = ic_last ? '0 : ic_r + COL_W'(1);
      ir_nxt = ic_last ? ir_r + IROW_W'(1) : ir_r;
      if (emit) begin
        oc_nxt = oc_last ? '0 : oc_r + COL_W'(1);
        or_nxt = oc_last ? or_r + ROW_W'(1) : or_r;
      end
      if (last) begin
        ic_nxt = '0;
        ir_nxt = '0;
        oc_nxt = '0;
        or_nxt = '0;
      end
      if (more) dcnt_nxt = dcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= FE_IDLE;
      ic_r    <= '0;
      ir_r    <= '0;
      oc_r    <= '0;
      or_r    <= '0;
      dcnt_r  <= '0;
      drain_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ic_r    <= ic_nxt;
      ir_r    <= ir_nxt;
      oc_r    <= oc_nxt;
      or_r    <= or_nxt;
      dcnt_r  <= dcnt_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  // Line stores: read at the column, then write back when the advance is queued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q  <= upper_mem[ic_r];
      mid_q <= middle_mem[ic_r];
    end
    if (q_push) begin
      upper_mem[ic_r]  <= mid_q;
      middle_mem[ic_r] <= pix_r;
    end
  end

  always_comb begin
    q_data.above    = up_q;
    q_data.middle   = mid_q;
    q_data.pix      = pix_r;
    q_data.emit     = emit;
    q_data.top_ok   = (or_r != '0);
    q_data.bot_ok   = !or_last;
    q_data.left_ok  = (oc_r != '0);
    q_data.right_ok = !oc_last;
    q_data.last     = last;
  end

endmodule

@@ sv/bb3_fifo.sv @@
// Short queue of window advances between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bb3_fifo import bb3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bb3_op_t push_data,
  output logic    full,
  input  logic    pop,
  output bb3_op_t pop_data,
  output logic    empty
);

  bb3_op_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_r + Q_AW'(1);
    if (pop)  rp_nxt = (rp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_r + Q_AW'(1);
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  `BB3_ASSERT_IMP(a_push_room, push, !full, "bb3_fifo: push while full")
  `BB3_ASSERT_IMP(a_pop_data, pop, !empty, "bb3_fifo: pop while empty")
  `BB3_ASSERT_NXT(a_count_up, push && !pop, cnt_r == $past(cnt_r) + Q_CW'(1), "bb3_fifo: count lost a push")

endmodule

@@ sv/bb3_back.sv @@
// Back end: 3x3 window, masked channel sums and rounded division.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bb3_back import bb3_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  output logic            q_pop,
  input  bb3_op_t         q_data,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] out_red,
  output logic [CH_W-1:0] out_green,
  output logic [CH_W-1:0] out_blue,
  output logic            out_last_pixel
);

  bk_state_t st_r, st_nxt;

  pix_t win_r [3][3];
  logic top_r, bot_r, left_r, right_r, last_r;
  logic [X_W-1:0]   xr_r, xg_r, xb_r;
  logic [CNT_W-1:0] cnt_r;

  logic [2:0]        row_en, col_en;
  logic [1:0]        rows, cols;
  logic [CNT_W-1:0]  cnt_c;
  logic [SUM_W-1:0]  sr, sg, sb;
  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] pr, pg, pb;
  logic out_valid_r, out_free, load_out, quot_ovf;

  assign row_en = {bot_r, 1'b1, top_r};
  assign col_en = {right_r, 1'b1, left_r};
  assign rows   = 2'd1 + 2'(top_r) + 2'(bot_r);
  assign cols   = 2'd1 + 2'(left_r) + 2'(right_r);
  assign cnt_c  = CNT_W'(rows) * CNT_W'(cols);

  // Masked sums over the window
  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_en[i] && col_en[j]) begin
          sr = sr + SUM_W'(win_r[i][j].red);
          sg = sg + SUM_W'(win_r[i][j].green);
          sb = sb + SUM_W'(win_r[i][j].blue);
        end
      end
    end
  end

  assign rcp      = bb3_recip(cnt_r);
  assign pr       = PROD_W'(xr_r) * PROD_W'(rcp);
  assign pg       = PROD_W'(xg_r) * PROD_W'(rcp);
  assign pb       = PROD_W'(xb_r) * PROD_W'(rcp);
  assign quot_ovf = (|pr[PROD_W-1:RCP_SH+CH_W]) || (|pg[PROD_W-1:RCP_SH+CH_W]) ||
                    (|pb[PROD_W-1:RCP_SH+CH_W]);
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (!q_empty) st_nxt = q_data.emit ? BK_SUM : BK_IDLE;
      BK_SUM:  st_nxt = BK_DIV;
      BK_DIV:  if (out_free) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (st_r)
      BK_IDLE: q_pop = !q_empty;
      BK_SUM:  q_pop = 1'b0;
      BK_DIV:  load_out = out_free;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Shift the window one column left and take the new column from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= q_data.above;
      win_r[1][2] <= q_data.middle;
      win_r[2][2] <= q_data.pix;
      top_r   <= q_data.top_ok;
      bot_r   <= q_data.bot_ok;
      left_r  <= q_data.left_ok;
      right_r <= q_data.right_ok;
      last_r  <= q_data.last;
    end
    if (st_r == BK_SUM) begin
      xr_r  <= (X_W'(sr) << 1) + X_W'(cnt_c);
      xg_r  <= (X_W'(sg) << 1) + X_W'(cnt_c);
      xb_r  <= (X_W'(sb) << 1) + X_W'(cnt_c);
      cnt_r <= cnt_c;
    end
    if (load_out) begin
      out_red        <= pr[RCP_SH +: CH_W];
      out_green      <= pg[RCP_SH +: CH_W];
      out_blue       <= pb[RCP_SH +: CH_W];
      out_last_pixel <= last_r;
    end
  end

  assign out_valid = out_valid_r;

  `BB3_ASSERT_NXT(a_div_loads, (st_r == BK_DIV) && out_free, out_valid_r, "bb3_back: result not loaded")
  `BB3_ASSERT_IMP(a_quot_fits, st_r == BK_DIV, !quot_ovf, "bb3_back: mean exceeds 8 bits")
  `BB3_ASSERT_IMP(a_sum_after_pop, st_r == BK_SUM, $past(q_pop) && $past(q_data.emit), "bb3_back: sum without an emitting advance")

endmodule

@@ sv/box_blur_three_by_three.sv @@
// Top level of the streaming 3x3 RGB box blur.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_stall  | in_req_type, in_red, in_green, in_blue
//   out     | out_valid/out_stall| out_red, out_green, out_blue, out_last_pixel
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pixel occupies the front while the line stores are read at the column,
// then written back and the advance is queued. A drain transaction queues
// one to three advances. The back handles an advance without a result in its
// shift step and one with a result in its shift, sum and divide steps; it
// takes no new advance until the divide step is done.
// Reset clears counters and control, sets width 1024 and height 480; the line
// stores are not cleared.
// out_stall holds the result register; the back then waits in its divide step,
// the 4-entry queue fills and in_stall stays high until room returns.
`timescale 1ns / 1ps

module box_blur_three_by_three import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  out_last_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WCFG_W-1:0] width_r, width_nxt;
  logic [HCFG_W-1:0] height_r, height_nxt;

  logic    q_full, q_empty, q_push, q_pop;
  bb3_op_t q_wdata, q_rdata;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_nxt  = cfg_data[WCFG_W-1:0];
        REG_HEIGHT: height_nxt = cfg_data[HCFG_W-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Front: accept transactions, advance positions, read and update line stores
  bb3_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .cfg_width   (width_r),
    .cfg_height  (height_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Queue: decouple the front from the arithmetic
  bb3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back: shift the window, sum the in-image neighbors, round the mean
  bb3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_data         (q_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last_pixel (out_last_pixel)
  );

endmodule
